// ----- design/petv_pkg.sv -----
package petv_pkg;

    localparam int ATOMS      = 1024;
    localparam int ATOM_W     = $clog2(ATOMS);
    localparam int ACC_W      = 64;
    localparam int VIR_N      = 6;
    localparam int ROW_WORDS  = VIR_N + 1;
    localparam int ROW_W      = ROW_WORDS * ACC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [2:0] REQ_PAIR   = 3'd0;
    localparam logic [2:0] REQ_FULL   = 3'd1;
    localparam logic [2:0] REQ_FORCE  = 3'd2;
    localparam logic [2:0] REQ_TOTALS = 3'd3;
    localparam logic [2:0] REQ_ATOM   = 3'd4;
    localparam logic [2:0] REQ_CLEAR  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_NEWTON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_E_ANY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_E_TOTAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_E_ATOM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_V_ANY     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_V_TOTAL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_V_ATOM    = 3'd7;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_VIR,
        S_TOT,
        S_RD_I,
        S_WR_I,
        S_RD_J,
        S_WR_J,
        S_RD_A,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [ATOM_W-1:0] rd_addr;
        logic              wr_en;
        logic [ATOM_W-1:0] wr_addr;
    } t_ram_ctl;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
            s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s;
    endfunction

endpackage

// ----- design/petv_atom_ram.sv -----
module petv_atom_ram (
    input  logic                        i_clk,
    input  petv_pkg::t_ram_ctl          i_ctl,
    input  logic [petv_pkg::ROW_W-1:0]  i_wr_data,
    output logic [petv_pkg::ROW_W-1:0]  o_rd_data
);

    logic [petv_pkg::ROW_W-1:0] r_mem [petv_pkg::ATOMS];
    logic [petv_pkg::ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/petv_vir_unit.sv -----
module petv_vir_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_force_mode,
    input  logic signed [23:0]        i_dx,
    input  logic signed [23:0]        i_dy,
    input  logic signed [23:0]        i_dz,
    input  logic signed [31:0]        i_fx,
    input  logic signed [31:0]        i_fy,
    input  logic signed [31:0]        i_fz,
    input  logic signed [31:0]        i_fp,
    output logic                      o_done,
    output logic [5:0][63:0]          o_vf,
    output logic [5:0][63:0]          o_vh
);

    logic signed [23:0] r_dx, r_dy, r_dz;
    logic signed [31:0] r_fx, r_fy, r_fz, r_fp;
    logic               r_mode;
    logic               r_issue;
    logic [2:0]         r_k;

    logic               r_s1_valid;
    logic [2:0]         r_s1_k;
    logic signed [47:0] r_s1_p;
    logic signed [31:0] r_s1_m;

    logic               r_s2_valid;
    logic [2:0]         r_s2_k;
    logic               r_s2_neg;
    logic [46:0]        r_s2_hi;
    logic [63:0]        r_s2_lo;

    logic               r_done;
    logic [5:0][63:0]   r_vf, r_vh;

    logic signed [23:0] op_a, op_b;
    logic signed [31:0] op_f;
    logic signed [47:0] ab_prod;
    logic signed [47:0] n_p;
    logic signed [31:0] n_m;
    logic [47:0]        p_abs;
    logic [31:0]        m_abs;
    logic [79:0]        big;
    logic [63:0]        full_mag, half_mag;

    always_comb begin
        case (r_k)
            3'd0: begin op_a = r_dx; op_b = r_dx; op_f = r_fx; end
            3'd1: begin op_a = r_dy; op_b = r_dy; op_f = r_fy; end
            3'd2: begin op_a = r_dz; op_b = r_dz; op_f = r_fz; end
            3'd3: begin op_a = r_dx; op_b = r_dy; op_f = r_fy; end
            3'd4: begin op_a = r_dx; op_b = r_dz; op_f = r_fz; end
            3'd5: begin op_a = r_dy; op_b = r_dz; op_f = r_fz; end
            default: begin op_a = r_dx; op_b = r_dx; op_f = r_fx; end
        endcase
        ab_prod = op_a * op_b;
        n_p = r_mode ? $signed({{24{op_a[23]}}, op_a}) : ab_prod;
        n_m = r_mode ? op_f : r_fp;
    end

    always_comb begin
        p_abs = r_s1_p[47] ? 48'(-r_s1_p) : r_s1_p;
        m_abs = r_s1_m[31] ? 32'(-r_s1_m) : r_s1_m;
    end

    always_comb begin
        big = {1'b0, r_s2_hi, 32'd0} + {16'd0, r_s2_lo};
        if (r_mode) begin
            full_mag = big[63:0];
            half_mag = 64'((big + 80'd1) >> 1);
        end else begin
            full_mag = 64'((big + 80'd32768) >> 16);
            half_mag = 64'((big + 80'd65536) >> 17);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue    <= 1'b0;
            r_k        <= 3'd0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (i_start) begin
                r_issue <= 1'b1;
                r_k     <= 3'd0;
            end else if (r_issue) begin
                r_k <= r_k + 3'd1;
                if (r_k == 3'd5) begin
                    r_issue <= 1'b0;
                end
            end
            r_s1_valid <= r_issue;
            r_s2_valid <= r_s1_valid;
            r_done     <= r_s2_valid && (r_s2_k == 3'd5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dx   <= i_dx;
            r_dy   <= i_dy;
            r_dz   <= i_dz;
            r_fx   <= i_fx;
            r_fy   <= i_fy;
            r_fz   <= i_fz;
            r_fp   <= i_fp;
            r_mode <= i_force_mode;
        end
        r_s1_k   <= r_k;
        r_s1_p   <= n_p;
        r_s1_m   <= n_m;
        r_s2_k   <= r_s1_k;
        r_s2_neg <= r_s1_p[47] ^ r_s1_m[31];
        r_s2_hi  <= p_abs[46:32] * m_abs;
        r_s2_lo  <= p_abs[31:0] * m_abs;
        if (r_s2_valid) begin
            r_vf[r_s2_k] <= r_s2_neg ? -full_mag : full_mag;
            r_vh[r_s2_k] <= r_s2_neg ? -half_mag : half_mag;
        end
    end

    assign o_done = r_done;
    assign o_vf   = r_vf;
    assign o_vh   = r_vh;

endmodule

// ----- design/pair_energy_virial_tally_core.sv -----
// Pair energy and virial tally core.
// Transactions enter on the input channel (i_in_valid, o_in_stall) and one
// is taken at a clock edge where i_in_valid is high and o_in_stall is low.
// Tally and clear transactions return nothing; a totals read returns eight
// result transactions and an atom read seven, on the output channel
// (o_out_valid, i_out_stall), with o_last marking the final one.
// Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data at any edge, and must only change while the core is idle.
// The core works on one transaction at a time. A tally keeps the input
// stalled while six virial components go through a three-stage multiplier
// pipeline, while the global totals are updated (once per local atom of the
// pair, or once for a full pair or with Newton on), and while each atom that
// is updated gets a read and a write-back on the single-port atom store. A
// totals read emits its results directly, and an atom read first reads its
// row from the store. A clear, and the end of reset, start a sweep of the
// atom store that writes one row per cycle, and input stays stalled until
// every row is written. While the receiver stalls, the current result is held
// in the output register and no further results are produced.
module pair_energy_virial_tally_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [2:0]                           i_req_type,
    input  logic [9:0]                           i_atom_a,
    input  logic [9:0]                           i_atom_b,
    input  logic signed [31:0]                   i_energy_vdw,
    input  logic signed [31:0]                   i_energy_coul,
    input  logic signed [31:0]                   i_pair_force,
    input  logic signed [23:0]                   i_dx,
    input  logic signed [23:0]                   i_dy,
    input  logic signed [23:0]                   i_dz,
    input  logic signed [31:0]                   i_force_x,
    input  logic signed [31:0]                   i_force_y,
    input  logic signed [31:0]                   i_force_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [63:0]                   o_value,
    output logic [2:0]                           o_component,
    output logic                                 o_last,
    input  logic                                 i_cfg_we,
    input  logic [petv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [petv_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW = petv_pkg::ATOM_W;

    petv_pkg::t_state r_state, n_state;

    logic        r_newton;
    logic [10:0] r_local_count;
    logic        r_e_any, r_e_tot, r_e_atom, r_v_any, r_v_tot, r_v_atom;

    logic signed [63:0] r_tot_vdw, r_tot_coul;
    logic [5:0][63:0]   r_tot_vir;

    logic [2:0]         r_req;
    logic [9:0]         r_a, r_b;
    logic signed [31:0] r_ev, r_ec;
    logic               r_use_full;
    logic               r_do_i, r_do_j, r_a_ok;
    logic [1:0]         r_tot_left;
    logic [AW-1:0]      r_clr_addr;
    logic [2:0]         r_k;

    logic               r_out_valid;
    logic signed [63:0] r_out_value;
    logic [2:0]         r_out_comp;
    logic               r_out_last;

    petv_pkg::t_ram_ctl           ram_ctl;
    logic [petv_pkg::ROW_W-1:0]   ram_wr_data, ram_rd_data;
    logic                         u_start, u_done;
    logic [5:0][63:0]             u_vf, u_vh;

    logic               accept, tot_add, out_load, in_range_a, in_range_b;
    logic               eg, ea, vg, va;
    logic signed [63:0] evf, ecf, evh, ech, eph, e_vdw_add, e_coul_add;
    logic [32:0]        e_sum;
    logic [5:0][63:0]   vir_add;
    logic [2:0]         last_k;
    logic signed [63:0] emit_value;
    logic [petv_pkg::ROW_W-1:0] new_row;

    petv_atom_ram u_ram (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_wr_data (ram_wr_data),
        .o_rd_data (ram_rd_data)
    );

    petv_vir_unit u_vir (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (u_start),
        .i_force_mode (i_req_type == petv_pkg::REQ_FORCE),
        .i_dx         (i_dx),
        .i_dy         (i_dy),
        .i_dz         (i_dz),
        .i_fx         (i_force_x),
        .i_fy         (i_force_y),
        .i_fz         (i_force_z),
        .i_fp         (i_pair_force),
        .o_done       (u_done),
        .o_vf         (u_vf),
        .o_vh         (u_vh)
    );

    assign eg = r_e_any && r_e_tot;
    assign ea = r_e_any && r_e_atom;
    assign vg = r_v_any && r_v_tot;
    assign va = r_v_any && r_v_atom;

    assign accept     = i_in_valid && (r_state == petv_pkg::S_IDLE);
    assign in_range_a = 32'(i_atom_a) < petv_pkg::ATOMS;
    assign in_range_b = 32'(i_atom_b) < petv_pkg::ATOMS;

    always_comb begin
        evf   = {{16{r_ev[31]}}, r_ev, 16'd0};
        ecf   = {{16{r_ec[31]}}, r_ec, 16'd0};
        evh   = {{17{r_ev[31]}}, r_ev, 15'd0};
        ech   = {{17{r_ec[31]}}, r_ec, 15'd0};
        e_sum = {r_ev[31], r_ev} + {r_ec[31], r_ec};
        eph   = {{16{e_sum[32]}}, e_sum, 15'd0};
        e_vdw_add  = r_use_full ? evf : evh;
        e_coul_add = r_use_full ? ecf : ech;
        vir_add    = r_use_full ? u_vf : u_vh;
    end

    always_comb begin
        new_row[63:0] = ea ? petv_pkg::sat_add(ram_rd_data[63:0], eph) : ram_rd_data[63:0];
        for (int w = 1; w < petv_pkg::ROW_WORDS; w++) begin
            new_row[w*64 +: 64] = va ? petv_pkg::sat_add(ram_rd_data[w*64 +: 64], u_vh[w-1])
                                     : ram_rd_data[w*64 +: 64];
        end
    end

    always_comb begin
        last_k = (r_req == petv_pkg::REQ_TOTALS) ? 3'd7 : 3'd6;
        if (r_req == petv_pkg::REQ_TOTALS) begin
            case (r_k)
                3'd0:    emit_value = r_tot_vdw;
                3'd1:    emit_value = r_tot_coul;
                default: emit_value = r_tot_vir[3'(r_k - 3'd2)];
            endcase
        end else begin
            emit_value = r_a_ok ? ram_rd_data[r_k*64 +: 64] : 64'sd0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            petv_pkg::S_CLEAR: begin
                if (r_clr_addr == AW'(petv_pkg::ATOMS - 1)) n_state = petv_pkg::S_IDLE;
            end
            petv_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type)
                        petv_pkg::REQ_PAIR,
                        petv_pkg::REQ_FULL,
                        petv_pkg::REQ_FORCE:  n_state = petv_pkg::S_VIR;
                        petv_pkg::REQ_TOTALS: n_state = petv_pkg::S_EMIT;
                        petv_pkg::REQ_ATOM:   n_state = petv_pkg::S_RD_A;
                        petv_pkg::REQ_CLEAR:  n_state = petv_pkg::S_CLEAR;
                        default:              n_state = petv_pkg::S_IDLE;
                    endcase
                end
            end
            petv_pkg::S_VIR: begin
                if (u_done) n_state = petv_pkg::S_TOT;
            end
            petv_pkg::S_TOT: begin
                if (r_tot_left == 2'd0) n_state = petv_pkg::S_RD_I;
            end
            petv_pkg::S_RD_I: n_state = r_do_i ? petv_pkg::S_WR_I : petv_pkg::S_RD_J;
            petv_pkg::S_WR_I: n_state = petv_pkg::S_RD_J;
            petv_pkg::S_RD_J: n_state = r_do_j ? petv_pkg::S_WR_J : petv_pkg::S_IDLE;
            petv_pkg::S_WR_J: n_state = petv_pkg::S_IDLE;
            petv_pkg::S_RD_A: n_state = petv_pkg::S_EMIT;
            petv_pkg::S_EMIT: begin
                if (out_load && (r_k == last_k)) n_state = petv_pkg::S_IDLE;
            end
            default: n_state = petv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ram_ctl     = '0;
        ram_wr_data = new_row;
        u_start     = 1'b0;
        tot_add     = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            petv_pkg::S_CLEAR: begin
                ram_ctl.wr_en   = 1'b1;
                ram_ctl.wr_addr = r_clr_addr;
                ram_wr_data     = '0;
            end
            petv_pkg::S_IDLE: begin
                u_start = accept && ((i_req_type == petv_pkg::REQ_PAIR) ||
                                     (i_req_type == petv_pkg::REQ_FULL) ||
                                     (i_req_type == petv_pkg::REQ_FORCE));
            end
            petv_pkg::S_TOT: begin
                tot_add = r_tot_left != 2'd0;
            end
            petv_pkg::S_RD_I: begin
                ram_ctl.rd_en   = r_do_i;
                ram_ctl.rd_addr = AW'(r_a);
            end
            petv_pkg::S_WR_I: begin
                ram_ctl.wr_en   = 1'b1;
                ram_ctl.wr_addr = AW'(r_a);
            end
            petv_pkg::S_RD_J: begin
                ram_ctl.rd_en   = r_do_j;
                ram_ctl.rd_addr = AW'(r_b);
            end
            petv_pkg::S_WR_J: begin
                ram_ctl.wr_en   = 1'b1;
                ram_ctl.wr_addr = AW'(r_b);
            end
            petv_pkg::S_RD_A: begin
                ram_ctl.rd_en   = 1'b1;
                ram_ctl.rd_addr = AW'(r_a);
            end
            petv_pkg::S_EMIT: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= petv_pkg::S_CLEAR;
            r_clr_addr    <= '0;
            r_newton      <= 1'b0;
            r_local_count <= '0;
            r_e_any       <= 1'b0;
            r_e_tot       <= 1'b0;
            r_e_atom      <= 1'b0;
            r_v_any       <= 1'b0;
            r_v_tot       <= 1'b0;
            r_v_atom      <= 1'b0;
            r_tot_vdw     <= '0;
            r_tot_coul    <= '0;
            r_tot_vir     <= '0;
            r_tot_left    <= '0;
            r_k           <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    petv_pkg::CFG_NEWTON:  r_newton      <= i_cfg_data[0];
                    petv_pkg::CFG_LOCAL:   r_local_count <= i_cfg_data;
                    petv_pkg::CFG_E_ANY:   r_e_any       <= i_cfg_data[0];
                    petv_pkg::CFG_E_TOTAL: r_e_tot       <= i_cfg_data[0];
                    petv_pkg::CFG_E_ATOM:  r_e_atom      <= i_cfg_data[0];
                    petv_pkg::CFG_V_ANY:   r_v_any       <= i_cfg_data[0];
                    petv_pkg::CFG_V_TOTAL: r_v_tot       <= i_cfg_data[0];
                    petv_pkg::CFG_V_ATOM:  r_v_atom      <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (r_state == petv_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end

            if (accept) begin
                r_k <= '0;
                if (i_req_type == petv_pkg::REQ_CLEAR) begin
                    r_clr_addr <= '0;
                    r_tot_vdw  <= '0;
                    r_tot_coul <= '0;
                    r_tot_vir  <= '0;
                end
                if ((i_req_type == petv_pkg::REQ_FULL) || r_newton) begin
                    r_tot_left <= 2'd1;
                end else begin
                    r_tot_left <= 2'({1'b0, {1'b0, i_atom_a} < r_local_count}) +
                                  2'({1'b0, {1'b0, i_atom_b} < r_local_count});
                end
            end

            if (tot_add) begin
                r_tot_left <= r_tot_left - 2'd1;
                if (eg) begin
                    r_tot_vdw  <= petv_pkg::sat_add(r_tot_vdw, e_vdw_add);
                    r_tot_coul <= petv_pkg::sat_add(r_tot_coul, e_coul_add);
                end
                if (vg) begin
                    for (int c = 0; c < petv_pkg::VIR_N; c++) begin
                        r_tot_vir[c] <= petv_pkg::sat_add(r_tot_vir[c], vir_add[c]);
                    end
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_k         <= r_k + 3'd1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= i_req_type;
            r_a        <= i_atom_a;
            r_b        <= i_atom_b;
            r_ev       <= i_energy_vdw;
            r_ec       <= i_energy_coul;
            r_use_full <= r_newton && (i_req_type != petv_pkg::REQ_FULL);
            r_a_ok     <= in_range_a;
            r_do_i     <= in_range_a && (ea || va) &&
                          ((i_req_type == petv_pkg::REQ_FULL) || r_newton ||
                           ({1'b0, i_atom_a} < r_local_count));
            r_do_j     <= in_range_b && (ea || va) && (i_req_type != petv_pkg::REQ_FULL) &&
                          (r_newton || ({1'b0, i_atom_b} < r_local_count));
        end
        if (out_load) begin
            r_out_value <= emit_value;
            r_out_comp  <= r_k;
            r_out_last  <= r_k == last_k;
        end
    end

    assign o_in_stall  = r_state != petv_pkg::S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_component = r_out_comp;
    assign o_last      = r_out_last;

    a_ram_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_ctl.rd_en && ram_ctl.wr_en))
        else $error("Atom store read and written in the same cycle.");

    a_vir_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_done |-> (r_state == petv_pkg::S_VIR))
        else $error("Virial unit finished outside the tally sequence.");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("A loaded result was not presented.");

    a_emit_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == petv_pkg::S_EMIT) |->
            ((r_req == petv_pkg::REQ_TOTALS) || (r_req == petv_pkg::REQ_ATOM)))
        else $error("Results emitted for a transaction that is not a read.");

endmodule
